// ===== src/snfcs_pkg.sv =====
`timescale 1ns / 1ps

package snfcs_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int MAX_RESULTS = 8;
   localparam int IDX_BITS = $clog2(MAX_RESULTS);
   localparam int CNT_BITS = $clog2(MAX_RESULTS + 1);

   localparam logic [2:0] ACT_READ_ID = 3'd0;
   localparam logic [2:0] ACT_READ    = 3'd1;
   localparam logic [2:0] ACT_PROGRAM = 3'd2;
   localparam logic [2:0] ACT_ERASE   = 3'd3;
   localparam logic [2:0] ACT_PAYLOAD = 3'd4;
   localparam logic [2:0] ACT_REPLY   = 3'd5;

   localparam logic [2:0] OP_SELECT   = 3'd0;
   localparam logic [2:0] OP_SEND     = 3'd1;
   localparam logic [2:0] OP_RECV     = 3'd2;
   localparam logic [2:0] OP_DESELECT = 3'd3;
   localparam logic [2:0] OP_HOST     = 3'd4;
   localparam logic [2:0] OP_IDDONE   = 3'd5;

   localparam logic [1:0] KIND_ID    = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_PROG  = 2'd2;
   localparam logic [1:0] KIND_ERASE = 2'd3;

   localparam logic [7:0] CMD_READ_ID      = 8'h9F;
   localparam logic [7:0] CMD_READ_STATUS  = 8'h05;
   localparam logic [7:0] CMD_READ         = 8'h03;
   localparam logic [7:0] CMD_WRITE_ENABLE = 8'h06;
   localparam logic [7:0] CMD_PROGRAM      = 8'h02;
   localparam logic [7:0] CMD_ERASE        = 8'h20;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ID,
      PH_POLL1,
      PH_POLL2,
      PH_READ,
      PH_PROG
   } phase_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  block;
      logic [3:0]  sector;
      logic [3:0]  page;
      logic [7:0]  offset;
      logic [15:0] length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  bus_op;
      logic [7:0]  bus_byte;
      logic [7:0]  manufacturer_id;
      logic [15:0] device_id;
      logic        last;
   } rsp_type;

endpackage

// ===== src/spi_nor_flash_command_sequencer_unit.sv =====
`timescale 1ns / 1ps

// Host side sequencer for a serial NOR flash. Each request on the req_ channel
// is a host command (read id, read, program, erase), a program payload byte or
// a reply byte from the bus. A request turns into zero to seven results on the
// rsp_ channel: bus operations (select, send byte, receive request, deselect),
// read data for the host, or id done with the JEDEC id. The last result of a
// request has last set.
// The results of a request are computed in the cycle it is accepted and are
// held in a result buffer; the first one is offered in the next cycle and one
// result leaves per cycle after that while rsp_stall is low. The next request
// is taken in the same cycle as the last result of the previous one, so a
// request can follow every cycle when each yields one result and rsp_stall
// stays low. A request that yields no result leaves the buffer empty.
// While rsp_stall is high the offered result holds, and req_stall is raised
// once the buffer is in use. Synchronous reset empties the buffer and returns
// the sequencer to idle with cleared address, length and id state.
module spi_nor_flash_command_sequencer_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  snfcs_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output snfcs_pkg::rsp_type rsp_payload
);
   import snfcs_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [1:0]             kind_ff, kind_in;
   logic [23:0]            addr_ff, addr_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic [23:0]            id_ff, id_in;
   logic [1:0]             idcnt_ff, idcnt_in;

   logic [2:0]             ops_ff [MAX_RESULTS];
   logic [2:0]             ops_in [MAX_RESULTS];
   logic [7:0]             bytes_ff [MAX_RESULTS];
   logic [7:0]             bytes_in [MAX_RESULTS];
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]    idx_ff;

   logic                   req_fire, rsp_fire, rsp_last;
   logic [23:0]            cmd_addr;
   logic [LENGTH_BITS-1:0] left_dec;
   logic [23:0]            id_shift;

   assign rsp_valid = cnt_ff != '0;
   assign rsp_last  = ({1'b0, idx_ff} + 1'b1) == cnt_ff;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign req_stall = rsp_valid && !(rsp_fire && rsp_last);
   assign req_fire  = req_valid && !req_stall;

   assign left_dec = left_ff - 1'b1;
   assign id_shift = {id_ff[15:0], req_payload.data_byte};
   assign cmd_addr = {req_payload.block, req_payload.sector,
                      (req_payload.action == ACT_ERASE) ? 12'h000 :
                      {req_payload.page, req_payload.offset}};

   always_comb begin
      logic [CNT_BITS-1:0] n;
      n        = '0;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      left_in  = left_ff;
      id_in    = id_ff;
      idcnt_in = idcnt_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         ops_in[i]   = OP_SELECT;
         bytes_in[i] = 8'h00;
      end
      case (phase_ff)
         PH_IDLE: begin
            if (req_payload.action <= ACT_ERASE) begin
               kind_in = req_payload.action[1:0];
               addr_in = cmd_addr;
               left_in = req_payload.length[LENGTH_BITS-1:0];
               ops_in[0] = OP_SELECT;
               ops_in[1] = OP_SEND;
               ops_in[2] = OP_RECV;
               n = CNT_BITS'(3);
               if (req_payload.action == ACT_READ_ID) begin
                  id_in       = '0;
                  idcnt_in    = '0;
                  bytes_in[1] = CMD_READ_ID;
                  phase_in    = PH_ID;
               end else begin
                  bytes_in[1] = CMD_READ_STATUS;
                  phase_in    = PH_POLL1;
               end
            end
         end
         PH_ID: begin
            if (req_payload.action == ACT_REPLY) begin
               id_in = id_shift;
               if (idcnt_ff < 2'd2) begin
                  idcnt_in  = idcnt_ff + 1'b1;
                  ops_in[0] = OP_RECV;
                  n = CNT_BITS'(1);
               end else begin
                  ops_in[0] = OP_DESELECT;
                  ops_in[1] = OP_IDDONE;
                  n = CNT_BITS'(2);
                  idcnt_in = '0;
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_POLL1, PH_POLL2: begin
            if (req_payload.action == ACT_REPLY) begin
               if (req_payload.data_byte[0]) begin
                  ops_in[0] = OP_RECV;
                  n = CNT_BITS'(1);
               end else begin
                  ops_in[0]   = OP_DESELECT;
                  ops_in[1]   = OP_SELECT;
                  ops_in[2]   = OP_SEND;
                  ops_in[3]   = OP_SEND;
                  ops_in[4]   = OP_SEND;
                  ops_in[5]   = OP_SEND;
                  bytes_in[3] = addr_ff[23:16];
                  bytes_in[4] = addr_ff[15:8];
                  bytes_in[5] = addr_ff[7:0];
                  if (kind_ff == KIND_READ) begin
                     bytes_in[2] = CMD_READ;
                     n = CNT_BITS'(7);
                     if (left_ff != '0) begin
                        ops_in[6] = OP_RECV;
                        phase_in  = PH_READ;
                     end else begin
                        ops_in[6] = OP_DESELECT;
                        phase_in  = PH_IDLE;
                     end
                  end else if (phase_ff == PH_POLL1 && kind_ff != KIND_ID) begin
                     bytes_in[2] = CMD_WRITE_ENABLE;
                     ops_in[3]   = OP_DESELECT;
                     ops_in[4]   = OP_SELECT;
                     ops_in[5]   = OP_SEND;
                     ops_in[6]   = OP_RECV;
                     bytes_in[3] = 8'h00;
                     bytes_in[4] = 8'h00;
                     bytes_in[5] = CMD_READ_STATUS;
                     n = CNT_BITS'(7);
                     phase_in = PH_POLL2;
                  end else if (kind_ff == KIND_PROG) begin
                     bytes_in[2] = CMD_PROGRAM;
                     if (left_ff != '0) begin
                        n = CNT_BITS'(6);
                        phase_in = PH_PROG;
                     end else begin
                        ops_in[6] = OP_DESELECT;
                        n = CNT_BITS'(7);
                        phase_in = PH_IDLE;
                     end
                  end else if (kind_ff == KIND_ERASE) begin
                     bytes_in[2] = CMD_ERASE;
                     ops_in[6]   = OP_DESELECT;
                     n = CNT_BITS'(7);
                     phase_in = PH_IDLE;
                  end else begin
                     n = CNT_BITS'(1);
                     phase_in = PH_IDLE;
                  end
               end
            end
         end
         PH_READ: begin
            if (req_payload.action == ACT_REPLY) begin
               ops_in[0]   = OP_HOST;
               bytes_in[0] = req_payload.data_byte;
               left_in     = left_dec;
               n = CNT_BITS'(2);
               if (left_dec == '0) begin
                  ops_in[1] = OP_DESELECT;
                  phase_in  = PH_IDLE;
               end else begin
                  ops_in[1] = OP_RECV;
               end
            end
         end
         PH_PROG: begin
            if (req_payload.action == ACT_PAYLOAD) begin
               ops_in[0]   = OP_SEND;
               bytes_in[0] = req_payload.data_byte;
               left_in     = left_dec;
               n = CNT_BITS'(1);
               if (left_dec == '0) begin
                  ops_in[1] = OP_DESELECT;
                  n = CNT_BITS'(2);
                  phase_in  = PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      cnt_in = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         kind_ff  <= '0;
         addr_ff  <= '0;
         left_ff  <= '0;
         id_ff    <= '0;
         idcnt_ff <= '0;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         addr_ff  <= addr_in;
         left_ff  <= left_in;
         id_ff    <= id_in;
         idcnt_ff <= idcnt_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= '0;
      end else if (rsp_fire) begin
         if (rsp_last) begin
            cnt_ff <= '0;
         end
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ops_ff   <= ops_in;
         bytes_ff <= bytes_in;
      end
   end

   always_comb begin
      rsp_payload.bus_op          = ops_ff[idx_ff];
      rsp_payload.bus_byte        = bytes_ff[idx_ff];
      rsp_payload.manufacturer_id = 8'h00;
      rsp_payload.device_id       = 16'h0000;
      rsp_payload.last            = rsp_last;
      if (ops_ff[idx_ff] == OP_IDDONE) begin
         rsp_payload.manufacturer_id = id_ff[23:16];
         rsp_payload.device_id       = id_ff[15:0];
      end
   end

`ifndef SYNTH
   a_iddone_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.bus_op == OP_IDDONE |-> rsp_payload.last)
      else $error("id done result is not the last of its request");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, idx_ff} < cnt_ff)
      else $error("result index beyond buffer fill");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_last && !req_valid |=> !rsp_valid)
      else $error("result buffer not empty after last result");
`endif

endmodule
